[sv/cse_pkg.sv]
package cse_pkg;

  localparam int DEF_MAX_COEFS = 64;
  localparam int DEF_FRAC_BITS = 16;

  localparam int Q_W       = 32;
  localparam int COUNT_W   = 7;
  localparam int INDEX_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                    mode;
    logic [INDEX_W-1:0]      coef_index;
    logic signed [Q_W-1:0]   coef_value;
    logic signed [Q_W-1:0]   sample;
  } item_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   series_value;
    logic                    saturated;
    logic                    bad_interval;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ABSV,
    ST_DIV,
    ST_ZSET,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic wr_coef;
    logic start;
    logic prep;
    logic absv;
    logic div_step;
    logic set_z;
    logic mul;
    logic acc;
    logic last;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic empty_iv;
    logic div_last;
    logic j_zero;
    logic slot_free;
  } status_t;

  typedef struct packed {
    logic signed [Q_W-1:0] value;
    logic                  clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'(Q_MAX)) begin
      r.value = Q_MAX;
      r.clip  = 1'b1;
    end else if (v < 66'(Q_MIN)) begin
      r.value = Q_MIN;
      r.clip  = 1'b1;
    end else begin
      r.value = v[Q_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

[sv/cse_ctrl.sv]
module cse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_mode,
  output logic              item_ready,
  input  cse_pkg::status_t  status,
  output cse_pkg::cmd_t     cmd
);
  import cse_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && item_mode == MODE_EVAL) begin
          state_next = status.empty_iv ? ST_FIN : ST_PREP;
        end
      end
      ST_PREP: state_next = ST_ABSV;
      ST_ABSV: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_ZSET;
        end
      end
      ST_ZSET: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = status.j_zero ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready  = 1'b1;
        cmd.wr_coef = item_valid && item_mode == MODE_LOAD;
        cmd.start   = item_valid && item_mode == MODE_EVAL;
      end
      ST_PREP: cmd.prep     = 1'b1;
      ST_ABSV: cmd.absv     = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_ZSET: cmd.set_z    = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_ACC: begin
        cmd.acc  = !status.j_zero;
        cmd.last = status.j_zero;
      end
      ST_FIN:  cmd.fin      = status.slot_free;
      default: cmd          = '0;
    endcase
  end

endmodule

[sv/cse_dpath.sv]
module cse_dpath #(
  parameter int MAX_COEFS = cse_pkg::DEF_MAX_COEFS,
  parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cse_pkg::item_t                   item,
  input  logic                             cfg_valid,
  input  logic [cse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cse_pkg::Q_W-1:0]          cfg_data,
  output logic                             result_valid,
  input  logic                             result_ready,
  output cse_pkg::result_t                 result,
  input  cse_pkg::cmd_t                    cmd,
  output cse_pkg::status_t                 status
);
  import cse_pkg::*;

  localparam int AW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;

  logic signed [Q_W-1:0]     interval_low;
  logic signed [Q_W-1:0]     interval_high;
  logic [COUNT_W-1:0]        coef_count;

  logic [Q_W-1:0]            coef_store [MAX_COEFS];
  logic signed [Q_W-1:0]     coef_rd;

  logic signed [Q_W-1:0]     s;
  logic signed [34:0]        num;
  logic signed [32:0]        den;
  logic [31:0]               ud;
  logic                      neg;
  logic                      ovf;
  logic [31:0]               rem;
  logic [32:0]               lo_bits;
  logic [32:0]               q;
  logic [DIV_CNT_W-1:0]      div_cnt;

  logic signed [Q_W-1:0]     z;
  logic signed [Q_W-1:0]     d;
  logic signed [Q_W-1:0]     dd;
  logic signed [63:0]        prod;
  logic [AW-1:0]             j;

  logic signed [Q_W-1:0]     res;
  logic                      clip;
  logic                      bad;

  logic [34:0]               num_mag;
  logic [32:0]               den_mag;
  logic [65:0]               un_sh;
  logic [64:0]               ud_sh;
  logic [32:0]               rs;
  logic                      rs_ge;
  logic signed [Q_W-1:0]     z_next;
  logic                      z_clip;
  logic signed [63:0]        prod_step;
  logic signed [63:0]        prod_last;
  logic signed [Q_W-1:0]     c_half;
  logic signed [65:0]        t_step;
  logic signed [65:0]        t_last;
  sat_t                      sat_step;
  sat_t                      sat_last;
  logic                      store_hit;

  assign status.empty_iv  = interval_high == interval_low;
  assign status.div_last  = div_cnt == '0;
  assign status.j_zero    = j == '0;
  assign status.slot_free = !result_valid || result_ready;

  assign store_hit = int'(item.coef_index) < MAX_COEFS;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_low  <= '0;
      interval_high <= 32'sd65536;
      coef_count    <= 7'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOW:   interval_low  <= cfg_data;
        CFG_HIGH:  interval_high <= cfg_data;
        CFG_COUNT: coef_count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_coef && store_hit) begin
      coef_store[AW'(item.coef_index)] <= item.coef_value;
    end
    if (cmd.mul) begin
      coef_rd <= coef_store[j];
    end
  end

  always_comb begin
    num_mag = num[34] ? 35'(-num) : 35'(num);
    den_mag = den[32] ? 33'(-den) : 33'(den);
    un_sh   = {33'b0, num_mag[32:0]} << FRAC_BITS;
    ud_sh   = {33'b0, den_mag[31:0]} << (33 - FRAC_BITS);
  end

  always_comb begin
    rs    = {rem, lo_bits[32]};
    rs_ge = rs >= {1'b0, ud};
  end

  always_comb begin
    z_clip = 1'b0;
    z_next = q[31:0];
    if (ovf || q[32]) begin
      z_clip = 1'b1;
      z_next = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      if (q[31:0] > 32'h8000_0000) begin
        z_clip = 1'b1;
        z_next = Q_MIN;
      end else begin
        z_next = -q[31:0];
      end
    end else if (q[31]) begin
      z_clip = 1'b1;
      z_next = Q_MAX;
    end
  end

  always_comb begin
    prod_step = prod >>> (FRAC_BITS - 1);
    prod_last = prod >>> FRAC_BITS;
    c_half    = coef_rd >>> 1;
    t_step    = 66'(prod_step) - 66'(dd) + 66'(coef_rd);
    t_last    = 66'(prod_last) - 66'(dd) + 66'(c_half);
    sat_step  = sat32(t_step);
    sat_last  = sat32(t_last);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s    <= item.sample;
      res  <= '0;
      clip <= 1'b0;
      bad  <= status.empty_iv;
    end
    if (cmd.prep) begin
      num <= (35'(s) <<< 1) - 35'(interval_low) - 35'(interval_high);
      den <= 33'(interval_high) - 33'(interval_low);
    end
    if (cmd.absv) begin
      neg     <= num[34] ^ den[32];
      ud      <= den_mag[31:0];
      ovf     <= {32'b0, num_mag[32:0]} >= ud_sh;
      rem     <= 32'(num_mag[32:0] >> (33 - FRAC_BITS));
      lo_bits <= un_sh[32:0];
      q       <= '0;
      div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem     <= rs_ge ? 32'(rs - {1'b0, ud}) : rs[31:0];
      lo_bits <= {lo_bits[31:0], 1'b0};
      q       <= {q[31:0], rs_ge};
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.set_z) begin
      z    <= z_next;
      clip <= clip | z_clip;
      d    <= '0;
      dd   <= '0;
      if (coef_count == '0) begin
        j <= '0;
      end else if (int'(coef_count) > MAX_COEFS) begin
        j <= AW'(MAX_COEFS - 1);
      end else begin
        j <= AW'(coef_count - 7'd1);
      end
    end
    if (cmd.mul) begin
      prod <= z * d;
    end
    if (cmd.acc) begin
      d    <= sat_step.value;
      dd   <= d;
      clip <= clip | sat_step.clip;
      j    <= j - 1'b1;
    end
    if (cmd.last) begin
      res  <= sat_last.value;
      clip <= clip | sat_last.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fin) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result.series_value <= res;
      result.saturated    <= clip;
      result.bad_interval <= bad;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!result_valid || result_ready))
    else $error("result register loaded while a result is still pending");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && !ovf) |-> (rem < ud))
    else $error("partial remainder reached the divisor");

  a_z_sign: assert property (@(posedge clk) disable iff (rst)
    (cmd.set_z && !ovf && !q[32] && !neg) |=> !z[31])
    else $error("mapped sample negative for a positive quotient");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && bad) |-> (res == '0 && !clip))
    else $error("empty interval result not forced to zero");

endmodule

[sv/chebyshev_series_evaluator_unit.sv]
// Evaluates a Chebyshev series by the Clenshaw recurrence in signed fixed point
// (Q16.16 by default) from a store of up to MAX_COEFS coefficients. A load
// request (mode 0) writes one coefficient and leaves the block idle. An evaluate
// request (mode 1) occupies the block for a setup sequence and a restoring
// divider that maps the sample onto [-1,1] one quotient bit per cycle, then, for
// each of N coefficients (the coefficient count clamped to 1..MAX_COEFS), a
// registered 32x32 multiply followed by the add-and-saturate step, and a final
// state that loads the result register once it is free. An empty interval goes
// straight to that final state with bad_interval set. Requests are taken only
// while no evaluation is in progress; a finished result waits in its own
// register and does not block the next request. Coefficient slots must be
// loaded before an evaluation reads them.
module chebyshev_series_evaluator_unit #(
  parameter int MAX_COEFS = cse_pkg::DEF_MAX_COEFS,
  parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  cse_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output cse_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cse_pkg::Q_W-1:0]        cfg_data
);
  import cse_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  cse_dpath #(
    .MAX_COEFS (MAX_COEFS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[dv/series_checker.sv]
`timescale 1ns / 100ps

module series_checker
  import cse_pkg::*;
#(
  parameter int MAX_COEFS = DEF_MAX_COEFS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  result_t              result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   compared
);

  localparam longint SAT_HI = longint'(Q_MAX);
  localparam longint SAT_LO = longint'(Q_MIN);

  logic signed [Q_W-1:0] coef_copy [MAX_COEFS];
  logic signed [Q_W-1:0] ivl_low;
  logic signed [Q_W-1:0] ivl_high;
  logic [COUNT_W-1:0]    coef_limit;
  result_t               awaited_values[$];

  function automatic longint clamp_q(input longint v, inout bit clipped);
    if (v > SAT_HI) begin
      clipped = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      clipped = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  function automatic result_t predict_series(input logic signed [Q_W-1:0] s);
    longint lo, hi, num, den, z, d, dd, prev, acc;
    longint unsigned un, ud, q, r, mag;
    bit neg, clipped;
    int n;
    result_t res;
    res = '0;
    lo = longint'(ivl_low);
    hi = longint'(ivl_high);
    if (hi == lo) begin
      res.bad_interval = 1'b1;
      return res;
    end
    clipped = 1'b0;
    num = 2 * longint'(s) - lo - hi;
    den = hi - lo;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = un / ud;
    r = un % ud;
    if (q >= (64'd1 << (Q_W - FRAC_BITS))) begin
      clipped = 1'b1;
      z = neg ? SAT_LO : SAT_HI;
    end else begin
      mag = (q << FRAC_BITS) + ((r << FRAC_BITS) / ud);
      if (neg) begin
        if (mag > 64'd2147483648) begin
          clipped = 1'b1;
          z = SAT_LO;
        end else begin
          z = -longint'(mag);
        end
      end else if (mag > 64'd2147483647) begin
        clipped = 1'b1;
        z = SAT_HI;
      end else begin
        z = longint'(mag);
      end
    end
    n = (coef_limit > MAX_COEFS) ? MAX_COEFS : int'(coef_limit);
    d = 0;
    dd = 0;
    for (int j = n; j >= 2; j--) begin
      prev = d;
      acc = ((z * d) >>> (FRAC_BITS - 1)) - dd + longint'(coef_copy[j-1]);
      d = clamp_q(acc, clipped);
      dd = prev;
    end
    acc = ((z * d) >>> FRAC_BITS) - dd + (longint'(coef_copy[0]) >>> 1);
    acc = clamp_q(acc, clipped);
    res.series_value = acc[Q_W-1:0];
    res.saturated = clipped;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ivl_low = '0;
      ivl_high = 32'sh0001_0000;
      coef_limit = 7'd1;
      awaited_values.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOW: begin
            ivl_low = cfg_data;
          end
          CFG_HIGH: begin
            ivl_high = cfg_data;
          end
          CFG_COUNT: begin
            coef_limit = cfg_data[COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (result_valid && result_ready) begin
        if (awaited_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h sat %b bad %b",
                     result.series_value, result.saturated, result.bad_interval);
        end else begin
          want = awaited_values.pop_front();
          compared++;
          if (result.series_value !== want.series_value ||
              result.saturated !== want.saturated ||
              result.bad_interval !== want.bad_interval) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h sat %b bad %b, got value %h sat %b bad %b",
                       want.series_value, want.saturated, want.bad_interval,
                       result.series_value, result.saturated, result.bad_interval);
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item.mode == MODE_EVAL)
          awaited_values.push_back(predict_series(item.sample));
        else if (item.coef_index < MAX_COEFS)
          coef_copy[item.coef_index] = item.coef_value;
      end
    end
    outstanding = awaited_values.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import cse_pkg::*;

  localparam int RANDOM_ITEMS = 1260;
  localparam int SETTLE = 8;
  localparam int TAIL = 200;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0]       cfg_data = '0;

  int mismatches, outstanding, compared;
  int stall_cycles = 0;
  int n_loads = 0, n_evals = 0, n_settings = 0;
  bit no_gaps = 1'b0;
  bit [DEF_MAX_COEFS-1:0] loaded = '0;
  logic signed [Q_W-1:0] cur_lo = '0;
  logic signed [Q_W-1:0] cur_hi = 32'sh0001_0000;

  always #10 clk = ~clk;

  chebyshev_series_evaluator_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  series_checker series_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
  );

  always @(negedge clk) begin
    result_ready <= no_gaps || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("chebyshev_series_evaluator_unit test failed");
      $finish;
    end
  end

  function automatic logic signed [Q_W-1:0] pick_coef();
    if ($urandom_range(0, 9) == 0)
      return $urandom;
    return $signed($urandom) >>> 13;
  endfunction

  function automatic logic signed [Q_W-1:0] pick_sample();
    longint span, v;
    if ($urandom_range(0, 4) == 0)
      return $urandom;
    span = longint'(cur_hi) - longint'(cur_lo);
    v = longint'(cur_lo) + (span * longint'($urandom_range(0, 65536))) / 65536;
    return v[Q_W-1:0];
  endfunction

  task automatic send_request(input item_t req);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 7) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic load_coef(input int idx, input logic signed [Q_W-1:0] value);
    item_t req;
    req.mode = MODE_LOAD;
    req.coef_index = idx[INDEX_W-1:0];
    req.coef_value = value;
    req.sample = $urandom;
    send_request(req);
    loaded[idx] = 1'b1;
    n_loads++;
  endtask

  task automatic evaluate(input logic signed [Q_W-1:0] s);
    item_t req;
    req.mode = MODE_EVAL;
    req.coef_index = INDEX_W'($urandom_range(0, 63));
    req.coef_value = $urandom;
    req.sample = s;
    send_request(req);
    n_evals++;
  endtask

  task automatic drain(input int settle);
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only with the block idle; slots that the new count reads are
  // loaded before any evaluation.
  task automatic reconfigure(input logic signed [Q_W-1:0] lo, input logic signed [Q_W-1:0] hi,
                             input int cnt, input bit spare_write);
    int used;
    drain(SETTLE);
    write_reg(CFG_LOW, lo);
    if (spare_write)
      write_reg(CFG_SPARE, $urandom);
    write_reg(CFG_HIGH, hi);
    write_reg(CFG_COUNT, 32'(cnt));
    cfg_valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    n_settings++;
    used = (cnt > DEF_MAX_COEFS) ? DEF_MAX_COEFS : ((cnt == 0) ? 1 : cnt);
    for (int j = 0; j < used; j++)
      if (!loaded[j])
        load_coef(j, pick_coef());
  endtask

  initial begin
    int random_items, phase, len, cnt;
    logic signed [Q_W-1:0] lo, hi, span;
    random_items = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_coef(0, 32'sh0001_0000);
    evaluate(32'sh0000_0000);
    evaluate(32'sh0000_8000);
    reconfigure(32'shFFFF_0000, 32'sh0001_0000, 4, 1'b0);
    load_coef(1, Q_MAX);
    load_coef(2, Q_MIN);
    load_coef(3, 32'sh0002_0000);
    evaluate(32'shFFFF_0000);
    evaluate(32'sh0001_0000);
    evaluate(Q_MAX);
    evaluate(Q_MIN);
    load_coef(63, 32'shFFFF_0000);
    load_coef(0, Q_MIN);
    evaluate(32'sh0000_4000);
    reconfigure(Q_MIN, Q_MAX, 2, 1'b1);
    evaluate(32'sh0000_0000);
    evaluate(Q_MAX);
    reconfigure(32'sh1234_0000, 32'sh1234_0000, 5, 1'b0);
    evaluate(pick_sample());
    reconfigure(32'sh0001_0000, 32'shFFFF_0000, 0, 1'b0);
    evaluate(32'sh0000_8000);

    while (random_items < RANDOM_ITEMS) begin
      span = $urandom_range(1 << 12, 16 << 16);
      lo = $signed($urandom) >>> 12;
      hi = lo + span;
      case ($urandom_range(0, 9))
        0: cnt = $urandom_range(0, 127);
        1: cnt = $urandom_range(11, 64);
        default: cnt = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin
          hi = lo;
        end
        2: begin
          hi = lo;
          lo = lo + span;
        end
        default: begin
        end
      endcase
      case (phase)
        0: begin
          lo = 32'shFFFF_0000;
          hi = 32'sh0001_0000;
          cnt = DEF_MAX_COEFS;
        end
        1: begin
          lo = '0;
          hi = 32'sh0004_0000;
          cnt = 127;
        end
        2: begin
          lo = Q_MIN;
          hi = Q_MAX;
          cnt = 0;
        end
        3: begin
          hi = lo;
        end
        4: begin
          lo = Q_MAX;
          hi = Q_MIN;
          cnt = 3;
        end
        default: begin
        end
      endcase
      no_gaps = (phase == 6) || (phase == 7);
      reconfigure(lo, hi, cnt, phase == 0);
      len = $urandom_range(30, 90);
      if (len > RANDOM_ITEMS - random_items)
        len = RANDOM_ITEMS - random_items;
      repeat (len) begin
        if ($urandom_range(0, 9) < 6)
          evaluate(pick_sample());
        else
          load_coef($urandom_range(0, 63), pick_coef());
        random_items++;
      end
      phase++;
    end
    no_gaps = 1'b0;
    drain(TAIL);

    $display("Run covered %0d coefficient loads and %0d evaluations over %0d register settings,",
             n_loads, n_evals, n_settings);
    $display("including empty, reversed and full-range intervals and counts 0 to 127; %0d checked.",
             compared);
    if (mismatches == 0)
      $display("chebyshev_series_evaluator_unit test passed");
    else
      $display("chebyshev_series_evaluator_unit test failed");
    $finish;
  end

endmodule
